### rtl/core/etm_pkg.sv
// ----------------------------------------------------------------------------
// etm_pkg: shared types and constants for the Euler transform matrix core
// Holds the Q.30 angle constants, the CORDIC arctangent table, row codes and
// the 32-bit saturation helper used by the matrix builder.
// ----------------------------------------------------------------------------
`default_nettype none

package etm_pkg;

    // Wide signed word for the Q.30 angle and CORDIC datapath.
    typedef logic signed [35:0] t_q30;

    // Matrix row number carried with each request.
    typedef logic [1:0] t_row;

    localparam t_row ROW_0 = 2'd0;
    localparam t_row ROW_1 = 2'd1;
    localparam t_row ROW_2 = 2'd2;
    localparam t_row ROW_3 = 2'd3;

    localparam t_q30 Q30_PI      = 36'sd3373259426;
    localparam t_q30 Q30_HALF_PI = 36'sd1686629713;
    localparam t_q30 Q30_TWO_PI  = 36'sd6746518852;
    localparam t_q30 Q30_GAIN    = 36'sd652032874;

    // Arctangent of 2^-i in Q.30.
    function automatic t_q30 atan_q30(input int idx);
        t_q30 v;
        unique case (idx)
            0:  v = 36'sd843314857;
            1:  v = 36'sd497837829;
            2:  v = 36'sd263043836;
            3:  v = 36'sd133525158;
            4:  v = 36'sd67021686;
            5:  v = 36'sd33543515;
            6:  v = 36'sd16775850;
            7:  v = 36'sd8388437;
            8:  v = 36'sd4194282;
            9:  v = 36'sd2097149;
            10: v = 36'sd1048575;
            11: v = 36'sd524287;
            12: v = 36'sd262143;
            13: v = 36'sd131071;
            14: v = 36'sd65535;
            15: v = 36'sd32767;
            16: v = 36'sd16383;
            17: v = 36'sd8191;
            18: v = 36'sd4095;
            19: v = 36'sd2047;
            20: v = 36'sd1023;
            21: v = 36'sd511;
            22: v = 36'sd255;
            23: v = 36'sd127;
            24: v = 36'sd63;
            25: v = 36'sd31;
            26: v = 36'sd15;
            27: v = 36'sd8;
            28: v = 36'sd4;
            29: v = 36'sd2;
            30: v = 36'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Clamp a matrix entry to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -34'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/core/etm_sincos.sv
// ----------------------------------------------------------------------------
// etm_sincos: pipelined sine and cosine
// Range reduction, one CORDIC rotation per register stage, then rounding to
// FRAC_BITS and clamping to [-1, 1], with the result registered.
// ----------------------------------------------------------------------------
`default_nettype none

module etm_sincos #(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_en,
    input  wire logic signed [15:0]        i_angle,
    output logic signed [FRAC_BITS+1:0]    o_sin,
    output logic signed [FRAC_BITS+1:0]    o_cos
);

    localparam int VW = FRAC_BITS + 2;
    localparam int RS = 30 - FRAC_BITS;
    localparam etm_pkg::t_q30 HALF  = (etm_pkg::t_q30'(1) <<< RS) >>> 1;
    localparam etm_pkg::t_q30 ONE_Q = etm_pkg::t_q30'(1) <<< FRAC_BITS;

    etm_pkg::t_q30 r_x   [0:CORDIC_STEPS];
    etm_pkg::t_q30 r_y   [0:CORDIC_STEPS];
    etm_pkg::t_q30 r_z   [0:CORDIC_STEPS];
    logic          r_neg [0:CORDIC_STEPS];

    etm_pkg::t_q30 n_z;
    logic          n_neg;
    etm_pkg::t_q30 n_cos;
    etm_pkg::t_q30 n_sin;
    logic signed [VW-1:0] r_sin;
    logic signed [VW-1:0] r_cos;

    // Widen to Q.30 and fold the angle into [-pi/2, pi/2].
    always_comb begin
        n_z = {{2{i_angle[15]}}, i_angle, 18'd0};
        if (n_z > etm_pkg::Q30_PI) n_z = n_z - etm_pkg::Q30_TWO_PI;
        if (n_z > etm_pkg::Q30_PI) n_z = n_z - etm_pkg::Q30_TWO_PI;
        if (n_z < -etm_pkg::Q30_PI) n_z = n_z + etm_pkg::Q30_TWO_PI;
        if (n_z < -etm_pkg::Q30_PI) n_z = n_z + etm_pkg::Q30_TWO_PI;
        n_neg = 1'b0;
        if (n_z > etm_pkg::Q30_HALF_PI) begin
            n_z   = n_z - etm_pkg::Q30_PI;
            n_neg = 1'b1;
        end else if (n_z < -etm_pkg::Q30_HALF_PI) begin
            n_z   = n_z + etm_pkg::Q30_PI;
            n_neg = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]   <= etm_pkg::Q30_GAIN;
            r_y[0]   <= '0;
            r_z[0]   <= n_z;
            r_neg[0] <= n_neg;
        end
    end

    // One CORDIC rotation per stage.
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_neg[i+1] <= r_neg[i];
                if (r_z[i] >= 0) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - etm_pkg::atan_q30(i);
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + etm_pkg::atan_q30(i);
                end
            end
        end
    end

    // Undo the half-turn fold, round to FRAC_BITS and clamp to [-1, 1].
    always_comb begin
        n_cos = r_neg[CORDIC_STEPS] ? -r_x[CORDIC_STEPS] : r_x[CORDIC_STEPS];
        n_sin = r_neg[CORDIC_STEPS] ? -r_y[CORDIC_STEPS] : r_y[CORDIC_STEPS];
        n_cos = (n_cos + HALF) >>> RS;
        n_sin = (n_sin + HALF) >>> RS;
        if (n_cos > ONE_Q)  n_cos = ONE_Q;
        if (n_cos < -ONE_Q) n_cos = -ONE_Q;
        if (n_sin > ONE_Q)  n_sin = ONE_Q;
        if (n_sin < -ONE_Q) n_sin = -ONE_Q;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cos <= n_cos[VW-1:0];
            r_sin <= n_sin[VW-1:0];
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

`default_nettype wire

### rtl/core/euler_trs_matrix_core.sv
// ----------------------------------------------------------------------------
// euler_trs_matrix_core: Euler rotation and translation matrix builder
// Builds M = Rx*Ry*Rz with the position in column 3 and emits it row by row.
// ----------------------------------------------------------------------------
// Each accepted request yields four result requests, rows 0 to 3, the last
// one flagged by o_last_row. Result rows come out at one per cycle while
// i_stall is low; while a matrix is being sent, a new request is taken only
// as its last row is accepted, set by the single result channel that
// carries one row per transfer. The input enters a pipeline of
// CORDIC_STEPS + 6 register stages (input, range reduction, one stage per
// CORDIC rotation, rounding, two product stages and a sum stage) into
// the row buffer that drives the rows. The block holds no state between
// requests; a stall on the result side holds the whole pipeline in place.
`default_nettype none

module euler_trs_matrix_core #(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic signed [31:0] i_pos_x,
    input  wire logic signed [31:0] i_pos_y,
    input  wire logic signed [31:0] i_pos_z,
    input  wire logic signed [15:0] i_angle_x,
    input  wire logic signed [15:0] i_angle_y,
    input  wire logic signed [15:0] i_angle_z,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [1:0]              o_row_index,
    output logic signed [31:0]      o_col_0,
    output logic signed [31:0]      o_col_1,
    output logic signed [31:0]      o_col_2,
    output logic signed [31:0]      o_col_3,
    output logic                    o_last_row
);

    localparam int VW = FRAC_BITS + 2;
    localparam int PW = 2 * VW;
    localparam int L  = CORDIC_STEPS + 2;
    localparam int D  = L + 3;
    localparam logic signed [31:0] ONE_OUT = 32'sd1 <<< FRAC_BITS;

    typedef logic signed [VW-1:0] t_val;

    // Product of two entries, rounded to nearest back to FRAC_BITS.
    function automatic t_val fmul(input t_val a, input t_val b);
        logic signed [PW-1:0] p;
        logic signed [PW-1:0] h;
        h = '0;
        h[FRAC_BITS-1] = 1'b1;
        p = PW'(a) * PW'(b);
        p = p + h;
        return t_val'(p >>> FRAC_BITS);
    endfunction

    logic en;

    logic               r_in_vld;
    logic signed [31:0] r_in_px, r_in_py, r_in_pz;
    logic signed [15:0] r_in_ax, r_in_ay, r_in_az;

    logic               r_vld [0:D-1];
    logic signed [31:0] r_px  [0:D-1];
    logic signed [31:0] r_py  [0:D-1];
    logic signed [31:0] r_pz  [0:D-1];

    t_val sx, cx, sy, cy, sz, cz;

    t_val r1_sxsy, r1_cxsy, r1_cycz, r1_cysz, r1_cxsz, r1_cxcz;
    t_val r1_sxcy, r1_sxsz, r1_sxcz, r1_cxcy, r1_sy, r1_sz, r1_cz;

    t_val r2_sxsycz, r2_sxsysz, r2_cxsycz, r2_cxsysz;
    t_val r2_cycz, r2_cysz, r2_cxsz, r2_cxcz, r2_sxcy, r2_sxsz, r2_sxcz;
    t_val r2_cxcy, r2_sy;

    logic signed [31:0] r3_m [0:8];

    logic               r_ser_valid;
    etm_pkg::t_row      r_row;
    logic signed [31:0] r_m  [0:8];
    logic signed [31:0] r_sx, r_sy, r_sz;

    // The pipeline moves whenever the row buffer is free or frees this cycle.
    assign en      = !r_ser_valid || (!i_stall && (r_row == etm_pkg::ROW_3));
    assign o_stall = !en;

    // Valid bits for the input register and the delay line.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            for (int k = 0; k < D; k++) r_vld[k] <= 1'b0;
        end else if (en) begin
            r_in_vld <= i_valid;
            r_vld[0] <= r_in_vld;
            for (int k = 1; k < D; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    // Input register and the position delay line.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in_px <= i_pos_x;
            r_in_py <= i_pos_y;
            r_in_pz <= i_pos_z;
            r_in_ax <= i_angle_x;
            r_in_ay <= i_angle_y;
            r_in_az <= i_angle_z;
            r_px[0] <= r_in_px;
            r_py[0] <= r_in_py;
            r_pz[0] <= r_in_pz;
            for (int k = 1; k < D; k++) begin
                r_px[k] <= r_px[k-1];
                r_py[k] <= r_py[k-1];
                r_pz[k] <= r_pz[k-1];
            end
        end
    end

    // Sine and cosine of each angle.
    etm_sincos #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_sc_x (
        .i_clk(i_clk), .i_en(en), .i_angle(r_in_ax), .o_sin(sx), .o_cos(cx)
    );
    etm_sincos #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_sc_y (
        .i_clk(i_clk), .i_en(en), .i_angle(r_in_ay), .o_sin(sy), .o_cos(cy)
    );
    etm_sincos #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_sc_z (
        .i_clk(i_clk), .i_en(en), .i_angle(r_in_az), .o_sin(sz), .o_cos(cz)
    );

    // First product stage: the pairwise products that the matrix needs.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_sxsy <= fmul(sx, sy);
            r1_cxsy <= fmul(cx, sy);
            r1_cycz <= fmul(cy, cz);
            r1_cysz <= fmul(cy, sz);
            r1_cxsz <= fmul(cx, sz);
            r1_cxcz <= fmul(cx, cz);
            r1_sxcy <= fmul(sx, cy);
            r1_sxsz <= fmul(sx, sz);
            r1_sxcz <= fmul(sx, cz);
            r1_cxcy <= fmul(cx, cy);
            r1_sy   <= sy;
            r1_sz   <= sz;
            r1_cz   <= cz;
        end
    end

    // Second product stage: triple products from the rounded pairs.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_sxsycz <= fmul(r1_sxsy, r1_cz);
            r2_sxsysz <= fmul(r1_sxsy, r1_sz);
            r2_cxsycz <= fmul(r1_cxsy, r1_cz);
            r2_cxsysz <= fmul(r1_cxsy, r1_sz);
            r2_cycz   <= r1_cycz;
            r2_cysz   <= r1_cysz;
            r2_cxsz   <= r1_cxsz;
            r2_cxcz   <= r1_cxcz;
            r2_sxcy   <= r1_sxcy;
            r2_sxsz   <= r1_sxsz;
            r2_sxcz   <= r1_sxcz;
            r2_cxcy   <= r1_cxcy;
            r2_sy     <= r1_sy;
        end
    end

    // Sum stage: form the rotation entries and saturate them.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_m[0] <= etm_pkg::sat32(34'(r2_cycz));
            r3_m[1] <= etm_pkg::sat32(-34'(r2_cysz));
            r3_m[2] <= etm_pkg::sat32(34'(r2_sy));
            r3_m[3] <= etm_pkg::sat32(34'(r2_cxsz) + 34'(r2_sxsycz));
            r3_m[4] <= etm_pkg::sat32(34'(r2_cxcz) - 34'(r2_sxsysz));
            r3_m[5] <= etm_pkg::sat32(-34'(r2_sxcy));
            r3_m[6] <= etm_pkg::sat32(34'(r2_sxsz) - 34'(r2_cxsycz));
            r3_m[7] <= etm_pkg::sat32(34'(r2_sxcz) + 34'(r2_cxsysz));
            r3_m[8] <= etm_pkg::sat32(34'(r2_cxcy));
        end
    end

    // Row sequencer control: load a finished matrix, then step the rows.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ser_valid <= 1'b0;
            r_row       <= etm_pkg::ROW_0;
        end else if (en) begin
            r_ser_valid <= r_vld[D-1];
            r_row       <= etm_pkg::ROW_0;
        end else if (!i_stall) begin
            r_row <= r_row + 2'd1;
        end
    end

    // Matrix buffer for the row sequencer.
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 9; k++) r_m[k] <= r3_m[k];
            r_sx <= r_px[D-1];
            r_sy <= r_py[D-1];
            r_sz <= r_pz[D-1];
        end
    end

    // Select the current row.
    always_comb begin
        unique case (r_row)
            etm_pkg::ROW_0: begin
                o_col_0 = r_m[0];
                o_col_1 = r_m[1];
                o_col_2 = r_m[2];
                o_col_3 = r_sx;
            end
            etm_pkg::ROW_1: begin
                o_col_0 = r_m[3];
                o_col_1 = r_m[4];
                o_col_2 = r_m[5];
                o_col_3 = r_sy;
            end
            etm_pkg::ROW_2: begin
                o_col_0 = r_m[6];
                o_col_1 = r_m[7];
                o_col_2 = r_m[8];
                o_col_3 = r_sz;
            end
            default: begin
                o_col_0 = '0;
                o_col_1 = '0;
                o_col_2 = '0;
                o_col_3 = ONE_OUT;
            end
        endcase
    end

    assign o_valid     = r_ser_valid;
    assign o_row_index = r_row;
    assign o_last_row  = (r_row == etm_pkg::ROW_3);

endmodule

`default_nettype wire
